@@ src/tgic_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgic_pkg
// Shared types, register codes and tables for the timer/GPIO interrupt
// controller.
// ----------------------------------------------------------------------------
package tgic_pkg;

  localparam int ENABLE_DELAY_DEPTH_DEF = 4;
  localparam int PORT_WIDTH_DEF         = 16;
  localparam int QUEUE_DEPTH            = 2;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_READ,
    OP_WRITE,
    OP_NOP
  } op_t;

  typedef enum logic [4:0] {
    REG_VECTOR    = 5'd0,
    REG_CAUSE     = 5'd1,
    REG_MASK      = 5'd2,
    REG_STATUS    = 5'd3,
    REG_EPC       = 5'd4,
    REG_S0CAUSE   = 5'd5,
    REG_GPIO_CAUSE = 5'd6,
    REG_GPIO_INV  = 5'd7,
    REG_GPIO_MASK = 5'd8,
    REG_PORT_DIR  = 5'd9,
    REG_PORT_OUT  = 5'd10,
    REG_PORT_IN   = 5'd11,
    REG_PIN_INV   = 5'd12,
    REG_PIN_MASK  = 5'd13,
    REG_TMR_CAUSE = 5'd14,
    REG_TMR_INV   = 5'd15,
    REG_TMR_MASK  = 5'd16,
    REG_TIMER0    = 5'd17,
    REG_TIMER1    = 5'd18,
    REG_TMR1_PRE  = 5'd19,
    REG_TMR1_CTC  = 5'd20,
    REG_TMR1_OCR  = 5'd21
  } reg_sel_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  sel;
    logic [31:0] wdata;
    logic        exc;
    logic [31:0] ret_pc;
  } cmd_t;

  // timer1 prescaler: low bits of timer0 that must be zero for a step
  function automatic logic [13:0] prescale_mask(input logic [2:0] sel);
    logic [13:0] m;
    case (sel)
      3'd1:    m = 14'd3;
      3'd2:    m = 14'd15;
      3'd3:    m = 14'd63;
      3'd4:    m = 14'd255;
      3'd5:    m = 14'd1023;
      3'd6:    m = 14'd4095;
      3'd7:    m = 14'd16383;
      default: m = 14'd0;
    endcase
    return m;
  endfunction

endpackage

@@ src/tgic_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgic_front
// Decodes an incoming item into an operation: unused selectors and writes
// to read-only registers become no-ops, exception is kept only on ticks.
// ----------------------------------------------------------------------------
module tgic_front import tgic_pkg::*; (
  input  logic [1:0]  command,
  input  logic [4:0]  reg_select,
  input  logic [31:0] write_data,
  input  logic        exception,
  input  logic [31:0] return_pc,
  output cmd_t        cmd
);

  logic readable;
  logic writable;

  always_comb begin
    readable = (reg_select <= REG_TMR1_OCR);
    writable = readable && !(reg_select inside {REG_CAUSE, REG_S0CAUSE, REG_PORT_IN,
                                                REG_TMR_CAUSE, REG_TIMER0});
  end

  always_comb begin
    cmd.sel    = reg_select;
    cmd.wdata  = write_data;
    cmd.ret_pc = return_pc;
    cmd.exc    = exception && (command == CMD_TICK);
    case (command)
      CMD_TICK:  cmd.op = OP_TICK;
      CMD_READ:  cmd.op = readable ? OP_READ : OP_NOP;
      CMD_WRITE: cmd.op = writable ? OP_WRITE : OP_NOP;
      default:   cmd.op = OP_NOP;
    endcase
  end

endmodule

@@ src/tgic_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgic_queue
// Small FIFO between decode and execute; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module tgic_queue import tgic_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = store[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

endmodule

@@ src/tgic_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgic_back
// Executes one item a cycle, unless a held result stalls it, against the
// register file: interrupt decision, enable delay line, GPIO and timer
// causes, register reads and writes. Results land in an output register.
// ----------------------------------------------------------------------------
module tgic_back import tgic_pkg::*; #(
  parameter int ENABLE_DELAY_DEPTH = ENABLE_DELAY_DEPTH_DEF,
  parameter int PORT_WIDTH         = PORT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  input  logic [PORT_WIDTH-1:0] q_pins,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           read_data,
  output logic                  irq_taken,
  output logic [31:0]           irq_target,
  output logic [PORT_WIDTH-1:0] port_out,
  output logic [PORT_WIDTH-1:0] port_dir
);

  localparam int D = ENABLE_DELAY_DEPTH;
  localparam int P = PORT_WIDTH;

  logic [31:0]  vector_base, vector_base_next;
  logic [31:0]  int_mask, int_mask_next;
  logic [31:0]  irq_enable, irq_enable_next;
  logic [31:0]  enable_delay [D];
  logic [31:0]  enable_delay_next [D];
  logic [31:0]  saved_pc, saved_pc_next;
  logic         int_pending, int_pending_next;
  logic [1:0]   summary_cause, summary_cause_next;
  logic [P-1:0] gpio_cause, gpio_cause_next;
  logic [P-1:0] gpio_cause_invert, gpio_cause_invert_next;
  logic [P-1:0] gpio_cause_mask, gpio_cause_mask_next;
  logic [P-1:0] port_direction, port_direction_next;
  logic [P-1:0] port_output, port_output_next;
  logic [P-1:0] port_input, port_input_next;
  logic [P-1:0] port_input_invert, port_input_invert_next;
  logic [P-1:0] port_input_mask, port_input_mask_next;
  logic [4:0]   timer_cause, timer_cause_next;
  logic [7:0]   timer_cause_invert, timer_cause_invert_next;
  logic [7:0]   timer_cause_mask, timer_cause_mask_next;
  logic [31:0]  free_timer, free_timer_next;
  logic [15:0]  count_timer, count_timer_next;
  logic [15:0]  prescale_select, prescale_select_next;
  logic [15:0]  compare_top, compare_top_next;
  logic [15:0]  output_compare, output_compare_next;

  logic [31:0]  rdata;
  logic         take;
  logic         ctc_match;
  logic [15:0]  count_base;
  logic         count_step;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    case (q_cmd.sel)
      REG_VECTOR:     rdata = vector_base;
      REG_CAUSE:      rdata = 32'(int_pending);
      REG_MASK:       rdata = int_mask;
      REG_STATUS:     rdata = irq_enable;
      REG_EPC:        rdata = saved_pc;
      REG_S0CAUSE:    rdata = 32'({summary_cause, 1'b0});
      REG_GPIO_CAUSE: rdata = 32'(gpio_cause);
      REG_GPIO_INV:   rdata = 32'(gpio_cause_invert);
      REG_GPIO_MASK:  rdata = 32'(gpio_cause_mask);
      REG_PORT_DIR:   rdata = 32'(port_direction);
      REG_PORT_OUT:   rdata = 32'(port_output);
      REG_PORT_IN:    rdata = 32'(port_input);
      REG_PIN_INV:    rdata = 32'(port_input_invert);
      REG_PIN_MASK:   rdata = 32'(port_input_mask);
      REG_TMR_CAUSE:  rdata = 32'(timer_cause);
      REG_TMR_INV:    rdata = 32'(timer_cause_invert);
      REG_TMR_MASK:   rdata = 32'(timer_cause_mask);
      REG_TIMER0:     rdata = free_timer;
      REG_TIMER1:     rdata = 32'(count_timer);
      REG_TMR1_PRE:   rdata = 32'(prescale_select);
      REG_TMR1_CTC:   rdata = 32'(compare_top);
      REG_TMR1_OCR:   rdata = 32'(output_compare);
      default:        rdata = '0;
    endcase
    if (q_cmd.op != OP_READ) begin
      rdata = '0;
    end
  end

  always_comb begin
    take       = ((irq_enable != '0) && int_pending && int_mask[0]) || q_cmd.exc;
    ctc_match  = (count_timer == compare_top);
    count_base = ctc_match ? '0 : count_timer;
    free_timer_next = free_timer;
    count_step = 1'b0;

    vector_base_next        = vector_base;
    int_mask_next           = int_mask;
    irq_enable_next         = irq_enable;
    enable_delay_next       = enable_delay;
    saved_pc_next           = saved_pc;
    int_pending_next        = int_pending;
    summary_cause_next      = summary_cause;
    gpio_cause_next         = gpio_cause;
    gpio_cause_invert_next  = gpio_cause_invert;
    gpio_cause_mask_next    = gpio_cause_mask;
    port_direction_next     = port_direction;
    port_output_next        = port_output;
    port_input_next         = port_input;
    port_input_invert_next  = port_input_invert;
    port_input_mask_next    = port_input_mask;
    timer_cause_next        = timer_cause;
    timer_cause_invert_next = timer_cause_invert;
    timer_cause_mask_next   = timer_cause_mask;
    count_timer_next        = count_timer;
    prescale_select_next    = prescale_select;
    compare_top_next        = compare_top;
    output_compare_next     = output_compare;

    case (q_cmd.op)
      OP_TICK: begin
        if (take) begin
          saved_pc_next = q_cmd.ret_pc;
        end
        irq_enable_next = take ? '0 : enable_delay[0];
        for (int i = 0; i < D - 1; i++) begin
          enable_delay_next[i] = take ? '0 : enable_delay[i + 1];
        end
        enable_delay_next[D-1] = take ? '0 : enable_delay[D-1];
        int_pending_next = (summary_cause != '0);

        port_input_next = q_pins;
        gpio_cause_next = P'(|((q_pins ^ port_input_invert) & port_input_mask));

        timer_cause_next[0] = free_timer[16];
        timer_cause_next[1] = free_timer[18];
        timer_cause_next[2] = timer_cause[2] ^ ctc_match;
        timer_cause_next[3] = (count_base < output_compare);
        timer_cause_next[4] = count_base[15];

        summary_cause_next[0] = |((gpio_cause_next ^ gpio_cause_invert) & gpio_cause_mask);
        summary_cause_next[1] = |(({3'b000, timer_cause_next} ^ timer_cause_invert)
                                  & timer_cause_mask);

        free_timer_next = free_timer + 32'd1;
        if (prescale_select inside {[16'd1:16'd7]}) begin
          count_step = ((free_timer_next[13:0] & prescale_mask(prescale_select[2:0]))
                        == '0);
        end else begin
          count_step = 1'b1;
        end
        count_timer_next = count_base + 16'(count_step);
      end
      OP_WRITE: begin
        case (q_cmd.sel)
          REG_VECTOR: vector_base_next = q_cmd.wdata;
          REG_MASK:   int_mask_next    = q_cmd.wdata;
          REG_STATUS: begin
            if (q_cmd.wdata == '0) begin
              irq_enable_next = '0;
              for (int i = 0; i < D; i++) begin
                enable_delay_next[i] = '0;
              end
            end else begin
              enable_delay_next[D-1] = q_cmd.wdata;
            end
          end
          REG_EPC:        saved_pc_next           = q_cmd.wdata;
          REG_GPIO_CAUSE: gpio_cause_next         = q_cmd.wdata[P-1:0];
          REG_GPIO_INV:   gpio_cause_invert_next  = q_cmd.wdata[P-1:0];
          REG_GPIO_MASK:  gpio_cause_mask_next    = q_cmd.wdata[P-1:0];
          REG_PORT_DIR:   port_direction_next     = q_cmd.wdata[P-1:0];
          REG_PORT_OUT:   port_output_next        = q_cmd.wdata[P-1:0];
          REG_PIN_INV:    port_input_invert_next  = q_cmd.wdata[P-1:0];
          REG_PIN_MASK:   port_input_mask_next    = q_cmd.wdata[P-1:0];
          REG_TMR_INV:    timer_cause_invert_next = q_cmd.wdata[7:0];
          REG_TMR_MASK:   timer_cause_mask_next   = q_cmd.wdata[7:0];
          REG_TIMER1:     count_timer_next        = q_cmd.wdata[15:0];
          REG_TMR1_PRE:   prescale_select_next    = q_cmd.wdata[15:0];
          REG_TMR1_CTC:   compare_top_next        = q_cmd.wdata[15:0];
          REG_TMR1_OCR:   output_compare_next     = q_cmd.wdata[15:0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_base        <= '0;
      int_mask           <= '0;
      irq_enable         <= '0;
      for (int i = 0; i < D; i++) begin
        enable_delay[i] <= '0;
      end
      saved_pc           <= '0;
      int_pending        <= 1'b0;
      summary_cause      <= '0;
      gpio_cause         <= '0;
      gpio_cause_invert  <= '0;
      gpio_cause_mask    <= '0;
      port_direction     <= '0;
      port_output        <= '0;
      port_input         <= '0;
      port_input_invert  <= '0;
      port_input_mask    <= '0;
      timer_cause        <= '0;
      timer_cause_invert <= '0;
      timer_cause_mask   <= '0;
      free_timer         <= '0;
      count_timer        <= '0;
      prescale_select    <= '0;
      compare_top        <= '0;
      output_compare     <= '0;
    end else if (q_pop) begin
      vector_base        <= vector_base_next;
      int_mask           <= int_mask_next;
      irq_enable         <= irq_enable_next;
      enable_delay       <= enable_delay_next;
      saved_pc           <= saved_pc_next;
      int_pending        <= int_pending_next;
      summary_cause      <= summary_cause_next;
      gpio_cause         <= gpio_cause_next;
      gpio_cause_invert  <= gpio_cause_invert_next;
      gpio_cause_mask    <= gpio_cause_mask_next;
      port_direction     <= port_direction_next;
      port_output        <= port_output_next;
      port_input         <= port_input_next;
      port_input_invert  <= port_input_invert_next;
      port_input_mask    <= port_input_mask_next;
      timer_cause        <= timer_cause_next;
      timer_cause_invert <= timer_cause_invert_next;
      timer_cause_mask   <= timer_cause_mask_next;
      free_timer         <= free_timer_next;
      count_timer        <= count_timer_next;
      prescale_select    <= prescale_select_next;
      compare_top        <= compare_top_next;
      output_compare     <= output_compare_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      read_data  <= rdata;
      irq_taken  <= (q_cmd.op == OP_TICK) && take;
      irq_target <= vector_base_next;
      port_out   <= port_output_next;
      port_dir   <= port_direction_next;
    end
  end

endmodule

@@ src/timer_gpio_interrupt_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_gpio_interrupt_controller
// Interrupt controller with timer and GPIO cause logic behind a register file.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: a tick, a
//   register read or a register write, with port pins, exception flag and
//   return pc. Output channel (out_valid/out_ready) returns exactly one
//   result item per command: read data, interrupt taken flag, vector, port
//   output and direction registers.
//   Order: an accepted input is first written into the decode queue, then
//   the execute stage pops it and loads the result register, which raises
//   out_valid; a stall on out_ready can hold the item in the queue.
//   Throughput: one item per cycle unless out_ready stalls, set by the single
//   execute stage that updates the whole register file once per item.
//   A two-entry queue sits between decode and execute; when out_ready is
//   low, the result register holds, the queue fills, and in_ready drops
//   once both entries are taken.
//   Reset clears every register of the register file, the enable delay line,
//   the queue and the result valid flag; in_ready is high the cycle after reset.
// ----------------------------------------------------------------------------
module timer_gpio_interrupt_controller import tgic_pkg::*; #(
  parameter int ENABLE_DELAY_DEPTH = ENABLE_DELAY_DEPTH_DEF,
  parameter int PORT_WIDTH         = PORT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  input  logic [4:0]            reg_select,
  input  logic [31:0]           write_data,
  input  logic [PORT_WIDTH-1:0] port_in,
  input  logic                  exception,
  input  logic [31:0]           return_pc,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           read_data,
  output logic                  irq_taken,
  output logic [31:0]           irq_target,
  output logic [PORT_WIDTH-1:0] port_out,
  output logic [PORT_WIDTH-1:0] port_dir
);

  localparam int QW = $bits(cmd_t) + PORT_WIDTH;

  cmd_t                  dec_cmd;
  cmd_t                  q_cmd;
  logic [PORT_WIDTH-1:0] q_pins;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic                  push;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  tgic_front u_front (
    .command    (command),
    .reg_select (reg_select),
    .write_data (write_data),
    .exception  (exception),
    .return_pc  (return_pc),
    .cmd        (dec_cmd)
  );

  tgic_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({dec_cmd, port_in}),
    .pop       (q_pop),
    .pop_data  ({q_cmd, q_pins}),
    .full      (q_full),
    .not_empty (q_valid)
  );

  tgic_back #(
    .ENABLE_DELAY_DEPTH (ENABLE_DELAY_DEPTH),
    .PORT_WIDTH         (PORT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pins     (q_pins),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .irq_taken  (irq_taken),
    .irq_target (irq_target),
    .port_out   (port_out),
    .port_dir   (port_dir)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("outputs not idle after reset");

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push |=> q_valid)
    else $error("accepted item not queued");

  a_taken_no_rdata: assert property (@(posedge clk) disable iff (rst)
    out_valid && irq_taken |-> read_data == '0)
    else $error("interrupt result carries read data");

  a_pop_only_free: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !q_pop)
    else $error("result overwritten while stalled");

endmodule

@@ tb/tb_timer_gpio_interrupt_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timer_gpio_interrupt_controller
// Self-checking bench for the timer/GPIO interrupt controller. A directed
// run covers register extremes, read-only and unused selectors, the enable
// delay line, exceptions and the timer1 compare match. Random commands
// follow, mostly interrupt and timer setup sequences with ticks, and both
// handshakes idle and stall at random. Every result is checked field by
// field against an in-bench model of the register file.
// ----------------------------------------------------------------------------
module tb_timer_gpio_interrupt_controller;
  import tgic_pkg::*;

  localparam logic [1:0] CMD_NOP       = 2'd3;
  localparam logic [4:0] SEL_UNUSED_LO = 5'd22;
  localparam logic [4:0] SEL_UNUSED_HI = 5'd31;
  localparam int         RANDOM_ITEMS  = 750;
  localparam int         HOLD_CYCLES   = 60;
  localparam int         DRAIN_CYCLES  = 8;
  localparam int         CYCLE_LIMIT   = 100000;

  typedef struct {
    logic [1:0]  cmd;
    logic [4:0]  sel;
    logic [31:0] wdata;
    logic [15:0] pins;
    logic        exc;
    logic [31:0] ret_pc;
  } ctrl_item_t;

  typedef struct {
    logic [31:0] rdata;
    logic        taken;
    logic [31:0] target;
    logic [15:0] pout;
    logic [15:0] pdir;
  } ctrl_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_TICK;
  logic [4:0]  reg_select = '0;
  logic [31:0] write_data = '0;
  logic [15:0] port_in = '0;
  logic        exception = 1'b0;
  logic [31:0] return_pc = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_data;
  logic        irq_taken;
  logic [31:0] irq_target;
  logic [15:0] port_out;
  logic [15:0] port_dir;

  timer_gpio_interrupt_controller uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .reg_select (reg_select),
    .write_data (write_data),
    .port_in    (port_in),
    .exception  (exception),
    .return_pc  (return_pc),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .irq_taken  (irq_taken),
    .irq_target (irq_target),
    .port_out   (port_out),
    .port_dir   (port_dir)
  );

  always #6 clk = ~clk;

  // controller model state
  logic [31:0] m_vector, m_mask, m_status, m_epc;
  logic [31:0] m_delay [ENABLE_DELAY_DEPTH_DEF];
  logic        m_cause;
  logic [2:0]  m_s0cause;
  logic [15:0] m_gpio_cause, m_gpio_inv, m_gpio_mask;
  logic [15:0] m_port_dir, m_port_out, m_port_in, m_pin_inv, m_pin_mask;
  logic [7:0]  m_tmr_cause, m_tmr_inv, m_tmr_mask;
  logic [31:0] m_timer0;
  logic [15:0] m_timer1, m_pre, m_ctc, m_ocr;

  ctrl_item_t   stim_q [$];
  ctrl_result_t ctrl_results_q [$];
  int           error_count = 0;
  int           results_seen = 0;
  int           cycle_count = 0;
  logic         in_fire = 1'b0;
  logic         out_fire = 1'b0;

  initial begin
    m_vector = '0; m_mask = '0; m_status = '0; m_epc = '0;
    foreach (m_delay[i]) m_delay[i] = '0;
    m_cause = 1'b0; m_s0cause = '0;
    m_gpio_cause = '0; m_gpio_inv = '0; m_gpio_mask = '0;
    m_port_dir = '0; m_port_out = '0; m_port_in = '0; m_pin_inv = '0; m_pin_mask = '0;
    m_tmr_cause = '0; m_tmr_inv = '0; m_tmr_mask = '0;
    m_timer0 = '0; m_timer1 = '0; m_pre = '0; m_ctc = '0; m_ocr = '0;
  end

  function automatic logic [31:0] reg_value(logic [4:0] sel);
    case (sel)
      REG_VECTOR:     return m_vector;
      REG_CAUSE:      return {31'd0, m_cause};
      REG_MASK:       return m_mask;
      REG_STATUS:     return m_status;
      REG_EPC:        return m_epc;
      REG_S0CAUSE:    return {29'd0, m_s0cause};
      REG_GPIO_CAUSE: return {16'd0, m_gpio_cause};
      REG_GPIO_INV:   return {16'd0, m_gpio_inv};
      REG_GPIO_MASK:  return {16'd0, m_gpio_mask};
      REG_PORT_DIR:   return {16'd0, m_port_dir};
      REG_PORT_OUT:   return {16'd0, m_port_out};
      REG_PORT_IN:    return {16'd0, m_port_in};
      REG_PIN_INV:    return {16'd0, m_pin_inv};
      REG_PIN_MASK:   return {16'd0, m_pin_mask};
      REG_TMR_CAUSE:  return {24'd0, m_tmr_cause};
      REG_TMR_INV:    return {24'd0, m_tmr_inv};
      REG_TMR_MASK:   return {24'd0, m_tmr_mask};
      REG_TIMER0:     return m_timer0;
      REG_TIMER1:     return {16'd0, m_timer1};
      REG_TMR1_PRE:   return {16'd0, m_pre};
      REG_TMR1_CTC:   return {16'd0, m_ctc};
      REG_TMR1_OCR:   return {16'd0, m_ocr};
      default:        return 32'd0;
    endcase
  endfunction

  function automatic void reg_store(logic [4:0] sel, logic [31:0] v);
    case (sel)
      REG_VECTOR: m_vector = v;
      REG_MASK:   m_mask = v;
      REG_STATUS: begin
        if (v == 32'd0) begin
          m_status = '0;
          foreach (m_delay[i]) m_delay[i] = '0;
        end else begin
          m_delay[ENABLE_DELAY_DEPTH_DEF-1] = v;
        end
      end
      REG_EPC:       m_epc = v;
      REG_GPIO_CAUSE: m_gpio_cause = v[15:0];
      REG_GPIO_INV:  m_gpio_inv = v[15:0];
      REG_GPIO_MASK: m_gpio_mask = v[15:0];
      REG_PORT_DIR:  m_port_dir = v[15:0];
      REG_PORT_OUT:  m_port_out = v[15:0];
      REG_PIN_INV:   m_pin_inv = v[15:0];
      REG_PIN_MASK:  m_pin_mask = v[15:0];
      REG_TMR_INV:   m_tmr_inv = v[7:0];
      REG_TMR_MASK:  m_tmr_mask = v[7:0];
      REG_TIMER1:    m_timer1 = v[15:0];
      REG_TMR1_PRE:  m_pre = v[15:0];
      REG_TMR1_CTC:  m_ctc = v[15:0];
      REG_TMR1_OCR:  m_ocr = v[15:0];
      default: ;
    endcase
  endfunction

  function automatic logic clock_tick(logic [15:0] pins, logic exc, logic [31:0] pc);
    logic        taken;
    logic [31:0] step_mask;
    taken = 1'b0;
    if ((m_status != 0 && (m_cause & m_mask[0])) || exc) begin
      m_epc = pc;
      m_status = '0;
      foreach (m_delay[i]) m_delay[i] = '0;
      taken = 1'b1;
    end
    m_status = m_delay[0];
    for (int i = 0; i < ENABLE_DELAY_DEPTH_DEF - 1; i++) m_delay[i] = m_delay[i+1];
    m_cause = (m_s0cause != 0);

    m_port_in = pins;
    m_gpio_cause = {15'd0, ((m_port_in ^ m_pin_inv) & m_pin_mask) != 0};

    m_tmr_cause[0] = m_timer0[16];
    m_tmr_cause[1] = m_timer0[18];
    if (m_timer1 == m_ctc) begin
      m_timer1 = '0;
      m_tmr_cause[2] = ~m_tmr_cause[2];
    end
    m_tmr_cause[3] = (m_timer1 < m_ocr);
    m_tmr_cause[4] = m_timer1[15];

    m_s0cause = '0;
    m_s0cause[1] = (((m_gpio_cause ^ m_gpio_inv) & m_gpio_mask) != 0);
    m_s0cause[2] = (((m_tmr_cause ^ m_tmr_inv) & m_tmr_mask) != 0);

    m_timer0 = m_timer0 + 32'd1;
    if (m_pre >= 1 && m_pre <= 7) begin
      step_mask = (32'd1 << (2 * m_pre)) - 32'd1;
      if ((m_timer0 & step_mask) == 0) m_timer1 = m_timer1 + 16'd1;
    end else begin
      m_timer1 = m_timer1 + 16'd1;
    end
    return taken;
  endfunction

  function automatic ctrl_result_t step_controller(ctrl_item_t it);
    ctrl_result_t r;
    r.rdata = '0;
    r.taken = 1'b0;
    case (it.cmd)
      CMD_TICK:  r.taken = clock_tick(it.pins, it.exc, it.ret_pc);
      CMD_READ:  r.rdata = reg_value(it.sel);
      CMD_WRITE: reg_store(it.sel, it.wdata);
      default: ;
    endcase
    r.target = m_vector;
    r.pout   = m_port_out;
    r.pdir   = m_port_dir;
    return r;
  endfunction

  function automatic void push_item(logic [1:0] cmd, logic [4:0] sel, logic [31:0] data,
                                    logic [15:0] pins, logic exc, logic [31:0] pc);
    ctrl_item_t it;
    it.cmd = cmd; it.sel = sel; it.wdata = data;
    it.pins = pins; it.exc = exc; it.ret_pc = pc;
    stim_q.push_back(it);
  endfunction

  function automatic void queue_write(logic [4:0] sel, logic [31:0] data);
    push_item(CMD_WRITE, sel, data, 16'($urandom), 1'($urandom_range(0, 1)), $urandom);
  endfunction

  function automatic void queue_read(logic [4:0] sel);
    push_item(CMD_READ, sel, $urandom, 16'($urandom), 1'($urandom_range(0, 1)), $urandom);
  endfunction

  function automatic void queue_tick(logic [15:0] pins, logic exc, logic [31:0] pc);
    push_item(CMD_TICK, 5'($urandom), $urandom, pins, exc, pc);
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 15);
      3:       return $urandom_range(0, 1023);
      default: return $urandom;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endfunction

  // driver
  int   in_gap = 0;
  logic in_quiet = 1'b0;

  always @(negedge clk) begin : drive_items
    ctrl_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (stim_q.size() != 0) begin
        it = stim_q.pop_front();
        command    <= it.cmd;
        reg_select <= it.sel;
        write_data <= it.wdata;
        port_in    <= it.pins;
        exception  <= it.exc;
        return_pc  <= it.ret_pc;
        in_valid   <= 1'b1;
        if ($urandom_range(0, 63) == 0) in_quiet = ~in_quiet;
        in_gap = in_quiet ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  int   out_stall = 0;
  int   out_hold = 0;
  logic out_quiet = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 63) == 0) out_quiet = ~out_quiet;
        out_stall = out_quiet ? 0 : $urandom_range(0, 3);
        if (results_seen == 200 || results_seen == 500) out_hold = HOLD_CYCLES;
      end
      if (out_hold > 0) begin
        out_ready <= 1'b0;
        out_hold--;
      end else if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_results
    ctrl_item_t   acc;
    ctrl_result_t want;
    if (rst) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && in_ready;
      out_fire <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        acc.cmd = command; acc.sel = reg_select; acc.wdata = write_data;
        acc.pins = port_in; acc.exc = exception; acc.ret_pc = return_pc;
        ctrl_results_q.push_back(step_controller(acc));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (ctrl_results_q.size() == 0) begin
          $error("result item with no expectation pending");
          error_count++;
        end else begin
          want = ctrl_results_q.pop_front();
          check_field("read_data", want.rdata, read_data);
          check_field("irq_taken", {31'd0, want.taken}, {31'd0, irq_taken});
          check_field("irq_target", want.target, irq_target);
          check_field("port_out", {16'd0, want.pout}, {16'd0, port_out});
          check_field("port_dir", {16'd0, want.pdir}, {16'd0, port_dir});
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n;
    int len;

    // directed
    queue_read(REG_VECTOR);
    queue_write(REG_VECTOR, 32'hFFFF_FFFF);
    queue_write(REG_MASK, 32'hFFFF_FFFF);
    queue_write(REG_PIN_MASK, 32'hFFFF_FFFF);
    queue_write(REG_GPIO_MASK, 32'hFFFF_FFFF);
    queue_write(REG_PORT_DIR, 32'hFFFF_FFFF);
    queue_write(REG_PORT_OUT, 32'hFFFF_5A5A);
    queue_write(REG_STATUS, 32'h0000_0001);
    queue_tick(16'hFFFF, 1'b0, 32'h1234_5678);
    queue_tick(16'h0000, 1'b0, 32'h0000_0000);
    queue_tick(16'hFFFF, 1'b0, 32'hFFFF_FFFF);
    queue_tick(16'h8001, 1'b0, 32'h8000_0001);
    queue_tick(16'hFFFF, 1'b0, 32'hDEAD_BEEF);
    queue_read(REG_EPC);
    queue_tick(16'h0000, 1'b1, 32'hFFFF_FFFF);
    queue_write(REG_STATUS, 32'h0);
    queue_write(REG_CAUSE, 32'hFFFF_FFFF);
    queue_write(REG_TIMER0, 32'hFFFF_FFFF);
    queue_write(SEL_UNUSED_HI, 32'hFFFF_FFFF);
    queue_read(SEL_UNUSED_LO);
    push_item(CMD_NOP, REG_VECTOR, 32'h0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    push_item(CMD_READ, REG_EPC, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'h0);
    queue_write(REG_TIMER1, 32'hFFFF_FFFF);
    queue_write(REG_TMR1_CTC, 32'hFFFF_FFFF);
    queue_write(REG_TMR1_OCR, 32'hFFFF_FFFF);
    queue_write(REG_TMR_MASK, 32'hFFFF_FFFF);
    queue_write(REG_TMR1_PRE, 32'h0000_0007);
    queue_tick(16'h0000, 1'b0, 32'h0);
    queue_read(REG_TMR_CAUSE);
    queue_read(REG_S0CAUSE);

    // random: mostly setup sequences followed by ticks
    n = 0;
    while (n < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: begin
          queue_write(REG_VECTOR, $urandom);
          queue_write(REG_MASK, $urandom_range(0, 3) != 0 ? 32'hFFFF_FFFF : $urandom);
          queue_write(REG_PIN_INV, $urandom);
          queue_write(REG_PIN_MASK, pick_data());
          queue_write(REG_GPIO_INV, $urandom_range(0, 3));
          queue_write(REG_GPIO_MASK, $urandom_range(0, 3));
          queue_write(REG_STATUS, $urandom_range(0, 7) != 0 ? $urandom : 32'h0);
          len = $urandom_range(4, 12);
          for (int i = 0; i < len; i++)
            queue_tick(16'($urandom), $urandom_range(0, 15) == 0, $urandom);
          queue_read(REG_EPC);
          queue_read(5'($urandom_range(0, 5)));
          n += len + 9;
        end
        1: begin
          queue_write(REG_TIMER1, $urandom_range(0, 15));
          queue_write(REG_TMR1_CTC, $urandom_range(0, 20));
          queue_write(REG_TMR1_OCR, $urandom_range(0, 20));
          queue_write(REG_TMR1_PRE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 9));
          queue_write(REG_TMR_INV, $urandom);
          queue_write(REG_TMR_MASK, $urandom);
          queue_write(REG_STATUS, $urandom_range(1, 255));
          len = $urandom_range(4, 16);
          for (int i = 0; i < len; i++)
            queue_tick(16'($urandom), $urandom_range(0, 31) == 0, $urandom);
          queue_read(5'($urandom_range(14, 21)));
          n += len + 8;
        end
        default: begin
          push_item($urandom_range(0, 15) == 0 ? CMD_NOP : 2'($urandom_range(0, 2)),
                    $urandom_range(0, 7) == 0
                      ? 5'($urandom_range(SEL_UNUSED_LO, SEL_UNUSED_HI))
                      : 5'($urandom_range(0, 21)),
                    pick_data(), 16'($urandom), $urandom_range(0, 7) == 0, $urandom);
          n++;
        end
      endcase
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || in_valid || ctrl_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (stim_q.size() != 0 || ctrl_results_q.size() != 0) begin
      $error("pending items: expected 0, got %0d", stim_q.size() + ctrl_results_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ timer_gpio_interrupt_controller.f @@
src/tgic_pkg.sv
src/tgic_front.sv
src/tgic_queue.sv
src/tgic_back.sv
src/timer_gpio_interrupt_controller.sv
tb/tb_timer_gpio_interrupt_controller.sv
